// ----- hw/rtl/assert_macros.svh -----
// Assertion macros shared by the fade block's RTL files.
// Relies on i_clk and i_rst_n being in scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock edge outside reset.
`define LCF_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Condition in one cycle implies a consequence in the next.
`define LCF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/lcf_pkg.sv -----
// Shared types and constants for the cubic fade LED driver.
// No dependencies; used by lcf_ctrl, lcf_datapath and led_cubic_fade_pwm.
`timescale 1ns / 1ps
`default_nettype none

package lcf_pkg;

    localparam int STEP_BITS_DEF   = 16;
    localparam int PERIOD_BITS_DEF = 12;

    localparam logic [31:0] PWM_PERIOD_RESET = 32'd1000;

    // stream payload widths
    localparam int KIND_W        = 3;
    localparam int STEP_FIELD_W  = 16;
    localparam int IN_TDATA_W    = 24;
    localparam int OUT_TDATA_W   = 8;
    localparam int APB_DATA_W    = 32;
    localparam int APB_ADDR_W    = 3;

    // register index, taken from paddr[2]
    localparam logic REG_PWM_PERIOD = 1'b0;

    typedef enum logic [KIND_W-1:0] {
        KIND_TICK   = 3'd0,
        KIND_START  = 3'd1,
        KIND_SET    = 3'd2,
        KIND_CLEAR  = 3'd3,
        KIND_TOGGLE = 3'd4
    } t_kind;

    // controller -> datapath
    typedef struct packed {
        logic exec;
        logic sqr;
        logic cube;
        logic mul;
        logic div;
        logic load;
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic need_calc;
        logic cnt_zero;
    } t_dp_stat;

    typedef struct packed {
        logic last;
        logic busy;
        logic led;
    } t_result;

endpackage

`default_nettype wire

// ----- hw/rtl/led_cubic_fade_pwm.sv -----
// LED driver with a cubic-eased PWM fade, top level: APB register, stream ports, result register.
// Depends on lcf_pkg, lcf_ctrl, lcf_datapath and assert_macros.svh.
//
// Each request on the input stream gives exactly one result on the output stream.
// Kinds (tuser): tick, start fade, set, clear, toggle. A start loads a fade of
// N steps; step i has on time floor(period * i^3 / N^3) (fade-in) or period
// minus that (fade-out), and lasts pwm_period ticks. While a fade runs only ticks
// do anything; the tick that ends the last step clears the LED and carries tlast.
// A start with N = 0 returns tlast at once and leaves the LED alone.
// A tick that closes a step but not the fade is followed by a gap in which no
// request is taken: a squaring step and a cubing step, then a shift-add multiply
// and a restoring divide that each retire one bit of the period per cycle.
// The period is latched on that tick, so register writes during the gap
// do not disturb it.
// A result waits in an output register; the next request is taken as long as that
// register is empty or being emptied in the same cycle.
// Register map: pwm_period at byte address 0 (reset 1000, low PERIOD_BITS used).
// New period values act at once on the step length; the on time follows at the
// next step boundary.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module led_cubic_fade_pwm #(
    parameter int STEP_BITS   = lcf_pkg::STEP_BITS_DEF,
    parameter int PERIOD_BITS = lcf_pkg::PERIOD_BITS_DEF
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    // input stream
    input  wire                               s_axis_tvalid,
    output logic                              s_axis_tready,
    input  wire [lcf_pkg::IN_TDATA_W-1:0]     s_axis_tdata,  // [0] fade_out, [16:1] fade_steps
    input  wire [lcf_pkg::KIND_W-1:0]         s_axis_tuser,  // [2:0] kind
    // result stream
    output logic                              m_axis_tvalid,
    input  wire                               m_axis_tready,
    output logic [lcf_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,  // [0] led_on, [1] busy_res
    output logic                              m_axis_tlast,  // last
    // configuration
    input  wire                               psel,
    input  wire                               penable,
    input  wire                               pwrite,
    input  wire [lcf_pkg::APB_ADDR_W-1:0]     paddr,
    input  wire [lcf_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [lcf_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready
);
    import lcf_pkg::*;

    logic [PERIOD_BITS-1:0] r_pwm_period;
    t_result                r_out;
    logic                   r_out_valid;

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;
    t_result  dp_res;
    logic     run;
    logic     accept;
    logic     reg_hit;

    // ---- configuration port ----
    assign pready  = 1'b1;
    assign reg_hit = (paddr[2] == REG_PWM_PERIOD);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pwm_period <= PWM_PERIOD_RESET[PERIOD_BITS-1:0];
        end else if (psel && penable && pwrite && pready && reg_hit) begin
            r_pwm_period <= pwdata[PERIOD_BITS-1:0];
        end
    end

    assign prdata = reg_hit ? APB_DATA_W'(r_pwm_period) : '0;

    // ---- request handshake ----
    // take a request when out of reset, the sequencer is free and the result slot will be free
    assign s_axis_tready = i_rst_n && run && (!r_out_valid || m_axis_tready);
    assign accept        = s_axis_tvalid && s_axis_tready;

    lcf_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_stat   (dp_stat),
        .o_cmd    (dp_cmd),
        .o_run    (run)
    );

    lcf_datapath #(
        .STEP_BITS   (STEP_BITS),
        .PERIOD_BITS (PERIOD_BITS)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (dp_cmd),
        .i_kind     (t_kind'(s_axis_tuser)),
        .i_fade_out (s_axis_tdata[0]),
        .i_steps    (s_axis_tdata[STEP_BITS:1]),
        .i_period   (r_pwm_period),
        .o_stat     (dp_stat),
        .o_res      (dp_res)
    );

    // ---- result register ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= dp_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OUT_TDATA_W - 2){1'b0}}, r_out.busy, r_out.led};
    assign m_axis_tlast  = r_out.last;

    `LCF_ASSERT(a_last_not_busy,
        (r_out_valid && r_out.last) |-> !r_out.busy,
        "fade end reported while still busy")
    `LCF_ASSERT(a_no_take_while_calc,
        accept |-> !(dp_cmd.sqr || dp_cmd.mul || dp_cmd.div),
        "request taken during step calculation")

endmodule

`default_nettype wire

// ----- hw/rtl/lcf_ctrl.sv -----
// Sequencer for the fade block: request execution and the eased on-time calculation.
// Depends on lcf_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module lcf_ctrl (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_accept,
    input  lcf_pkg::t_dp_stat i_stat,
    output lcf_pkg::t_dp_cmd  o_cmd,
    output logic              o_run
);
    import lcf_pkg::*;

    typedef enum logic [5:0] {
        ST_RUN  = 6'b000001,
        ST_SQR  = 6'b000010,
        ST_CUBE = 6'b000100,
        ST_MUL  = 6'b001000,
        ST_DIV  = 6'b010000,
        ST_LOAD = 6'b100000
    } t_ctrl_state;

    t_ctrl_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_RUN: begin
                o_cmd.exec = i_accept;
                if (i_accept && i_stat.need_calc) begin
                    n_state = ST_SQR;
                end
            end
            ST_SQR: begin
                o_cmd.sqr = 1'b1;
                n_state   = ST_CUBE;
            end
            ST_CUBE: begin
                o_cmd.cube = 1'b1;
                n_state    = ST_MUL;
            end
            ST_MUL: begin
                o_cmd.mul = 1'b1;
                if (i_stat.cnt_zero) begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                o_cmd.div = 1'b1;
                if (i_stat.cnt_zero) begin
                    n_state = ST_LOAD;
                end
            end
            ST_LOAD: begin
                o_cmd.load = 1'b1;
                n_state    = ST_RUN;
            end
            default: begin
                n_state = ST_RUN;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_RUN;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_run = (r_state == ST_RUN);

    `LCF_ASSERT_NEXT(a_div_ends_in_load, (r_state == ST_DIV) && i_stat.cnt_zero, r_state == ST_LOAD, "divide did not hand over to load")
    `LCF_ASSERT_NEXT(a_calc_follows_boundary, i_accept && i_stat.need_calc, r_state == ST_SQR, "step boundary did not start calculation")

endmodule

`default_nettype wire

// ----- hw/rtl/lcf_datapath.sv -----
// Fade state, PWM phase logic and the shift-add multiply / restoring divide
// that give floor(period * i^3 / N^3). Depends on lcf_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module lcf_datapath #(
    parameter int STEP_BITS   = lcf_pkg::STEP_BITS_DEF,
    parameter int PERIOD_BITS = lcf_pkg::PERIOD_BITS_DEF
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  lcf_pkg::t_dp_cmd      i_cmd,
    input  lcf_pkg::t_kind        i_kind,
    input  wire                   i_fade_out,
    input  wire [STEP_BITS-1:0]   i_steps,
    input  wire [PERIOD_BITS-1:0] i_period,
    output lcf_pkg::t_dp_stat     o_stat,
    output lcf_pkg::t_result      o_res
);
    import lcf_pkg::*;

    localparam int SQ_W   = 2 * STEP_BITS;
    localparam int CUBE_W = 3 * STEP_BITS;
    localparam int NUM_W  = PERIOD_BITS + CUBE_W;
    localparam int CNT_W  = $clog2(PERIOD_BITS);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(PERIOD_BITS - 1);

    // fade state
    logic                   r_led, n_led;
    logic                   r_fading, n_fading;
    logic                   r_dir, n_dir;
    logic [STEP_BITS-1:0]   r_total, n_total;
    logic [STEP_BITS-1:0]   r_step, n_step;
    logic [PERIOD_BITS-1:0] r_phase, n_phase;
    logic [PERIOD_BITS-1:0] r_on, n_on;
    logic [PERIOD_BITS-1:0] r_per_l, n_per_l;
    logic                   n_last;
    logic                   n_need_calc;

    // calculation registers
    logic [SQ_W-1:0]        r_sq_i, r_sq_n;
    logic [CUBE_W-1:0]      r_cube_i, r_cube_n;
    logic [NUM_W-1:0]       r_num;
    logic [NUM_W-1:0]       r_den;
    logic [PERIOD_BITS-1:0] r_quo;
    logic [CNT_W-1:0]       r_cnt;

    logic [PERIOD_BITS:0]   phase_inc;
    logic [STEP_BITS-1:0]   step_inc;
    logic [NUM_W-1:0]       mul_add;

    assign phase_inc = {1'b0, r_phase} + (PERIOD_BITS + 1)'(1);
    assign step_inc  = r_step + STEP_BITS'(1);

    always_comb begin
        n_led       = r_led;
        n_fading    = r_fading;
        n_dir       = r_dir;
        n_total     = r_total;
        n_step      = r_step;
        n_phase     = r_phase;
        n_on        = r_on;
        n_per_l     = r_per_l;
        n_last      = 1'b0;
        n_need_calc = 1'b0;
        if (i_cmd.exec) begin
            if (r_fading) begin
                if (i_kind == KIND_TICK) begin
                    n_led = (r_phase < r_on);
                    if (phase_inc >= {1'b0, i_period}) begin
                        n_phase = '0;
                        n_step  = step_inc;
                        if (step_inc >= r_total) begin
                            n_fading = 1'b0;
                            n_led    = 1'b0;
                            n_last   = 1'b1;
                        end else begin
                            // on time of the new step is worked out after this request
                            n_need_calc = 1'b1;
                            n_per_l     = i_period;
                        end
                    end else begin
                        n_phase = phase_inc[PERIOD_BITS-1:0];
                    end
                end
            end else begin
                unique case (i_kind)
                    KIND_START: begin
                        if (i_steps == '0) begin
                            n_last = 1'b1;
                        end else begin
                            n_fading = 1'b1;
                            n_dir    = i_fade_out;
                            n_total  = i_steps;
                            n_step   = '0;
                            n_phase  = '0;
                            // step zero: cube term is zero
                            n_on     = i_fade_out ? i_period : '0;
                        end
                    end
                    KIND_SET:    n_led = 1'b1;
                    KIND_CLEAR:  n_led = 1'b0;
                    KIND_TOGGLE: n_led = ~r_led;
                    default: begin
                    end
                endcase
            end
        end
        if (i_cmd.load) begin
            n_on = r_dir ? (r_per_l - r_quo) : r_quo;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_led    <= 1'b0;
            r_fading <= 1'b0;
            r_dir    <= 1'b0;
            r_total  <= '0;
            r_step   <= '0;
            r_phase  <= '0;
            r_on     <= '0;
            r_per_l  <= '0;
        end else begin
            r_led    <= n_led;
            r_fading <= n_fading;
            r_dir    <= n_dir;
            r_total  <= n_total;
            r_step   <= n_step;
            r_phase  <= n_phase;
            r_on     <= n_on;
            r_per_l  <= n_per_l;
        end
    end

    // MSB-first shift-add of period * i^3
    assign mul_add = r_per_l[r_cnt] ? NUM_W'(r_cube_i) : '0;

    always_ff @(posedge i_clk) begin
        if (i_cmd.sqr) begin
            r_sq_i <= SQ_W'(r_step) * SQ_W'(r_step);
            r_sq_n <= SQ_W'(r_total) * SQ_W'(r_total);
        end
        if (i_cmd.cube) begin
            r_cube_i <= CUBE_W'(r_sq_i) * CUBE_W'(r_step);
            r_cube_n <= CUBE_W'(r_sq_n) * CUBE_W'(r_total);
            r_num    <= '0;
            r_cnt    <= CNT_LAST;
        end
        if (i_cmd.mul) begin
            r_num <= {r_num[NUM_W-2:0], 1'b0} + mul_add;
            r_den <= NUM_W'(r_cube_n) << (PERIOD_BITS - 1);
            r_cnt <= (r_cnt == '0) ? CNT_LAST : r_cnt - CNT_W'(1);
        end
        if (i_cmd.div) begin
            // quotient fits PERIOD_BITS since i < N
            if (r_num >= r_den) begin
                r_num <= r_num - r_den;
                r_quo <= {r_quo[PERIOD_BITS-2:0], 1'b1};
            end else begin
                r_quo <= {r_quo[PERIOD_BITS-2:0], 1'b0};
            end
            r_den <= r_den >> 1;
            r_cnt <= r_cnt - CNT_W'(1);
        end
    end

    assign o_stat.need_calc = n_need_calc;
    assign o_stat.cnt_zero  = (r_cnt == '0);

    assign o_res.led  = n_led;
    assign o_res.busy = n_fading;
    assign o_res.last = n_last;

    `LCF_ASSERT(a_step_in_range, r_fading |-> (r_step < r_total), "step index reached step count while fading")
    `LCF_ASSERT(a_quo_below_period, i_cmd.load |-> ((r_quo < r_per_l) || (r_per_l == '0)), "eased on time not below period")

endmodule

`default_nettype wire
